// ----- rtl/core/deadline_slot_scheduler_core_macros.svh -----
// Assertion macros for the deadline slot scheduler.
`ifndef DEADLINE_SLOT_SCHEDULER_CORE_MACROS_SVH
`define DEADLINE_SLOT_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTH
`define DSS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DSS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define DSS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/dss_pkg.sv -----
package dss_pkg;
    localparam int PRI_W = 16;
    localparam int DL_W  = 8;
    localparam int IDX_W = 6;
    // Output word: job_index, slot, none_scheduled, overflow, end_of_run.
    typedef struct packed {
        logic       end_of_run;
        logic       overflow;
        logic       none_scheduled;
        logic [5:0] slot;
        logic [5:0] job_index;
    } result_t;
endpackage

// ----- rtl/core/deadline_slot_scheduler_core.sv -----
// Job sequencing with deadlines. Jobs load one word per cycle on the s_ side
// (tdata = priority, deadline; tlast closes the set). Up to MAX_JOBS jobs are
// held; later jobs of the set are dropped and every result of that set has
// overflow set. After the last word the block takes no input while it
// schedules. A selection sort scans the priority memory once per pass, one
// read a cycle; n passes pick the jobs and one more pass finds none left.
// Each picked job then loads its deadline, skips down past taken slots and
// takes the latest free slot below its deadline, or gives up. The schedule
// is then read from the slot owner memory from the latest slot down, and
// output stalls hold that read.
// One result word is given per scheduled job, or a single word with
// none_scheduled set when no job got a slot.
module deadline_slot_scheduler_core #(
    parameter int MAX_JOBS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] priority_req, [23:16] deadline
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] job_index, [11:6] slot, [12] none_scheduled,
                                   // [13] overflow, [15:14] zero
    output logic        m_tlast    // end_of_run
);
    import dss_pkg::*;
    `include "deadline_slot_scheduler_core_macros.svh"

    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int RD = 1 << AW;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_SRCH = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_NONE = 3'd5;
    localparam logic [2:0] ST_LIM  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [MAX_JOBS-1:0] taken_reg, taken_next;
    logic [MAX_JOBS-1:0] used_reg, used_next;
    logic [CW-1:0]       ptr_reg, ptr_next;      // scan read address / slot cursor
    logic                rv_reg, rv_next;        // read data valid for address ptr-1
    logic [AW-1:0]       radr_reg, radr_next;
    logic                best_v_reg, best_v_next;
    logic [PRI_W-1:0]    best_p_reg, best_p_next;
    logic [AW-1:0]       best_i_reg, best_i_next;
    logic [CW-1:0]       lim_reg, lim_next;
    logic [CW-1:0]       picks_reg, picks_next;
    logic                mv_reg, mv_next;
    result_t             res_reg, res_next;

    logic [PRI_W-1:0] pri_q;
    logic [DL_W-1:0]  dl_q;
    logic [AW-1:0]    own_q;
    logic             acc, st_we, own_we;
    logic [AW-1:0]    st_wa, own_wa, pri_ra, own_ra;
    logic [AW-1:0]    lim_m1;
    logic             more_later;
    logic [CW-1:0]    dl_cap;

    assign s_tready = (state_reg == ST_LOAD);
    assign acc      = s_tvalid && s_tready;
    assign st_we    = acc && (count_reg < CW'(MAX_JOBS));
    assign st_wa    = count_reg[AW-1:0];
    assign lim_m1   = AW'(lim_reg - 1'b1);

    dss_ram #(.WIDTH(PRI_W), .DEPTH(RD)) u_pri (
        .aclk(aclk), .we(st_we), .waddr(st_wa), .wdata(s_tdata[15:0]),
        .raddr(pri_ra), .rdata(pri_q));
    dss_ram #(.WIDTH(DL_W), .DEPTH(RD)) u_dl (
        .aclk(aclk), .we(st_we), .waddr(st_wa), .wdata(s_tdata[23:16]),
        .raddr(best_i_next), .rdata(dl_q));
    dss_ram #(.WIDTH(AW), .DEPTH(RD)) u_own (
        .aclk(aclk), .we(own_we), .waddr(own_wa), .wdata(best_i_reg),
        .raddr(own_ra), .rdata(own_q));

    assign pri_ra = ptr_reg[AW-1:0];
    assign own_ra = AW'(ptr_reg - 1'b1);
    assign own_we = (state_reg == ST_SRCH) && (lim_reg != '0) && !taken_reg[lim_m1];
    assign own_wa = lim_m1;
    assign dl_cap = (CW'(dl_q) > count_reg || dl_q > DL_W'(MAX_JOBS)) ? count_reg
                                                                       : CW'(dl_q);
    // Any taken slot below the cursor still to emit.
    always_comb begin
        more_later = 1'b0;
        for (int i = 0; i < MAX_JOBS; i++) begin
            if (CW'(i) < ptr_reg - 1'b1 && taken_reg[i]) more_later = 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        taken_next  = taken_reg;
        used_next   = used_reg;
        ptr_next    = ptr_reg;
        rv_next     = 1'b0;
        radr_next   = radr_reg;
        best_v_next = best_v_reg;
        best_p_next = best_p_reg;
        best_i_next = best_i_reg;
        lim_next    = lim_reg;
        picks_next  = picks_reg;
        mv_next     = mv_reg;
        res_next    = res_reg;
        if (mv_reg && m_tready) mv_next = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (acc) begin
                    if (count_reg < CW'(MAX_JOBS)) count_next = count_reg + 1'b1;
                    else ovf_next = 1'b1;
                    if (s_tlast) begin
                        state_next  = ST_SCAN;
                        ptr_next    = '0;
                        best_v_next = 1'b0;
                        picks_next  = '0;
                        used_next   = '0;
                    end
                end
            end
            ST_SCAN: begin
                // Compare the word read last cycle; first strict max wins ties.
                if (rv_reg && !used_reg[radr_reg] &&
                    (!best_v_reg || pri_q > best_p_reg)) begin
                    best_v_next = 1'b1;
                    best_p_next = pri_q;
                    best_i_next = radr_reg;
                end
                if (ptr_reg < count_next && ptr_reg < CW'(MAX_JOBS)) begin
                    rv_next   = 1'b1;
                    radr_next = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                end else if (!rv_reg) begin
                    if (picks_reg == count_reg) begin
                        state_next = ST_EMIT;
                        ptr_next   = count_reg;
                        rv_next    = 1'b0;
                    end else begin
                        // Deadline read is addressed by best_i_next this cycle.
                        state_next = ST_LIM;
                        used_next[best_i_reg] = 1'b1;
                    end
                end
            end
            ST_LIM: begin
                // The picked job's deadline is on the read port now.
                lim_next   = dl_cap;
                state_next = ST_SRCH;
            end
            ST_SRCH: begin
                if (lim_reg == '0 || !taken_reg[lim_m1]) begin
                    if (lim_reg != '0) taken_next[lim_m1] = 1'b1;
                    picks_next  = picks_reg + 1'b1;
                    state_next  = ST_SCAN;
                    ptr_next    = '0;
                    best_v_next = 1'b0;
                end else begin
                    lim_next = lim_reg - 1'b1;
                end
            end
            ST_EMIT: begin
                // Owner read of slot ptr-1 is issued here; its data is used in ST_OUT.
                if (ptr_reg == '0) begin
                    state_next = ST_NONE;
                end else if (taken_reg[AW'(ptr_reg - 1'b1)]) begin
                    state_next = ST_OUT;
                end else begin
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    res_next.job_index      = IDX_W'(own_q);
                    res_next.slot           = IDX_W'(ptr_reg - 1'b1);
                    res_next.none_scheduled = 1'b0;
                    res_next.overflow       = ovf_reg;
                    res_next.end_of_run     = !more_later;
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = more_later ? ST_EMIT : ST_LOAD;
                    if (!more_later) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        taken_next = '0;
                    end
                end
            end
            ST_NONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next  = 1'b1;
                    res_next = '{end_of_run: 1'b1, overflow: ovf_reg,
                                 none_scheduled: 1'b1, slot: '0, job_index: '0};
                    state_next = ST_LOAD;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    taken_next = '0;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            taken_reg  <= '0;
            used_reg   <= '0;
            ptr_reg    <= '0;
            rv_reg     <= 1'b0;
            best_v_reg <= 1'b0;
            picks_reg  <= '0;
            mv_reg     <= 1'b0;
            lim_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            taken_reg  <= taken_next;
            used_reg   <= used_next;
            ptr_reg    <= ptr_next;
            rv_reg     <= rv_next;
            best_v_reg <= best_v_next;
            picks_reg  <= picks_next;
            mv_reg     <= mv_next;
            lim_reg    <= lim_next;
        end
        radr_reg   <= radr_next;
        best_p_reg <= best_p_next;
        best_i_reg <= best_i_next;
        res_reg    <= res_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, res_reg.overflow, res_reg.none_scheduled,
                       res_reg.slot, res_reg.job_index};
    assign m_tlast  = res_reg.end_of_run;

    `DSS_ASSERT_IMPL(a_ready_load, aclk, aresetn, s_tready, state_reg == ST_LOAD)
    `DSS_ASSERT_IMPL(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_JOBS))
    `DSS_ASSERT_IMPL(a_picks_cap, aclk, aresetn, state_reg != ST_LOAD, picks_reg <= count_reg)
    `DSS_ASSERT_NEXT(a_clear_after, aclk, aresetn,
        mv_next && res_next.end_of_run && !mv_reg, taken_reg == '0)
endmodule

// ----- rtl/core/dss_ram.sv -----
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
